@@ design/assert_macros.svh @@
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/el2hp_pkg.sv @@
// Types and constants of the Ethernet L2 header parser.
package el2hp_pkg;

    localparam logic [2:0] ST_ACCEPT    = 3'd0;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
    localparam logic [2:0] ST_LENGTH    = 3'd2;
    localparam logic [2:0] ST_NOT_UCAST = 3'd3;
    localparam logic [2:0] ST_RUNT      = 3'd4;
    localparam logic [2:0] ST_TAGS      = 3'd5;

    localparam logic [1:0] REG_LENGTH_LIMIT = 2'd0;
    localparam logic [1:0] REG_TYPE_FLOOR   = 2'd1;
    localparam logic [1:0] REG_CTAG_TYPE    = 2'd2;
    localparam logic [1:0] REG_STAG_TYPE    = 2'd3;

    localparam logic [15:0] RST_LENGTH_LIMIT = 16'd1500;
    localparam logic [15:0] RST_TYPE_FLOOR   = 16'd1536;
    localparam logic [15:0] RST_CTAG_TYPE    = 16'h8100;
    localparam logic [15:0] RST_STAG_TYPE    = 16'h88A8;

    localparam logic [5:0] POS_SRC_ADDR = 6'd6;
    localparam logic [5:0] POS_TYPE_HI  = 6'd12;
    localparam logic [5:0] POS_TYPE_LO  = 6'd13;
    localparam logic [5:0] POS_MAX      = 6'd63;
    localparam logic [5:0] BASE_HDR_LEN = 6'd14;

    typedef struct packed {
        logic [15:0] length_limit;
        logic [15:0] type_floor;
        logic [15:0] ctag_type;
        logic [15:0] stag_type;
    } t_cfg;

    typedef struct packed {
        logic [5:0]  header_len;
        logic [15:0] frame_type;
        logic [2:0]  status;
    } t_result;

endpackage

@@ design/el2hp_byte_parser.sv @@
// Per-byte frame state and verdict logic of the Ethernet L2 header parser.
module el2hp_byte_parser #(
    parameter int MAX_TAGS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  el2hp_pkg::t_cfg    i_cfg,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output logic               o_emit,
    output el2hp_pkg::t_result o_result
);

    logic [5:0]  r_pos, n_pos;
    logic [5:0]  r_off, n_off;
    logic [15:0] r_shift, n_shift;
    logic [3:0]  r_flags, n_flags;
    logic [2:0]  r_tags, n_tags;
    logic        r_done, n_done;
    logic [15:0] r_ptype, n_ptype;
    logic        r_pstag, n_pstag;

    logic        take_en;
    logic        is_ctag;
    logic        is_stag;
    logic        addr_ok;
    logic [6:0]  tag_end;

    assign tag_end = 7'(r_off) + (r_pstag ? 7'd7 : 7'd3);

    always_comb begin
        n_pos    = r_pos;
        n_off    = r_off;
        n_shift  = r_shift;
        n_flags  = r_flags;
        n_tags   = r_tags;
        n_done   = r_done;
        n_ptype  = r_ptype;
        n_pstag  = r_pstag;
        o_emit   = 1'b0;
        o_result = '0;
        take_en  = 1'b0;
        is_ctag  = 1'b0;
        is_stag  = 1'b0;
        addr_ok  = 1'b0;
        if (i_accept) begin
            if (!r_done) begin
                n_shift = {r_shift[7:0], i_byte};
                if (r_pos < el2hp_pkg::POS_TYPE_HI) begin
                    if (r_pos < el2hp_pkg::POS_SRC_ADDR) begin
                        if (i_byte != 8'd0) n_flags[0] = 1'b1;
                        if (r_pos == 6'd0 && i_byte[0]) n_flags[1] = 1'b1;
                    end else begin
                        if (i_byte != 8'd0) n_flags[2] = 1'b1;
                        if (r_pos == el2hp_pkg::POS_SRC_ADDR && i_byte[0]) n_flags[3] = 1'b1;
                    end
                end else if (r_pos == el2hp_pkg::POS_TYPE_LO) begin
                    if (n_shift >= i_cfg.length_limit && n_shift <= i_cfg.type_floor) begin
                        o_emit   = 1'b1;
                        o_result = '{header_len: 6'd0, frame_type: n_shift,
                                     status: el2hp_pkg::ST_BAD_TYPE};
                    end else if (n_shift < i_cfg.length_limit) begin
                        o_emit   = 1'b1;
                        o_result = '{header_len: 6'd0, frame_type: n_shift,
                                     status: el2hp_pkg::ST_LENGTH};
                    end else begin
                        n_off   = el2hp_pkg::BASE_HDR_LEN;
                        take_en = 1'b1;
                    end
                end else if (r_pos > el2hp_pkg::POS_TYPE_LO && tag_end == 7'(r_pos)) begin
                    n_off   = r_off + (r_pstag ? 6'd8 : 6'd4);
                    n_tags  = r_tags + 3'd1;
                    take_en = 1'b1;
                end

                addr_ok = n_flags[0] && !n_flags[1] && n_flags[2] && !n_flags[3];
                is_ctag = (n_shift == i_cfg.ctag_type);
                is_stag = (n_shift == i_cfg.stag_type);

                if (take_en) begin
                    if (is_ctag || is_stag) begin
                        if (n_tags >= 3'(MAX_TAGS)) begin
                            o_emit   = 1'b1;
                            o_result = '{header_len: n_off, frame_type: n_shift,
                                         status: el2hp_pkg::ST_TAGS};
                        end else begin
                            n_ptype = n_shift;
                            n_pstag = !is_ctag;
                        end
                    end else begin
                        o_emit   = 1'b1;
                        o_result = '{header_len: n_off, frame_type: n_shift,
                                     status: addr_ok ? el2hp_pkg::ST_ACCEPT
                                                     : el2hp_pkg::ST_NOT_UCAST};
                    end
                end

                if (i_last && !o_emit) begin
                    o_emit = 1'b1;
                    if (r_pos < el2hp_pkg::POS_TYPE_LO) begin
                        o_result = '{header_len: 6'd0, frame_type: 16'd0,
                                     status: el2hp_pkg::ST_RUNT};
                    end else begin
                        o_result = '{header_len: n_off, frame_type: n_ptype,
                                     status: addr_ok ? el2hp_pkg::ST_ACCEPT
                                                     : el2hp_pkg::ST_NOT_UCAST};
                    end
                end
                if (o_emit) n_done = 1'b1;
            end

            if (i_last) begin
                n_pos   = '0;
                n_off   = '0;
                n_shift = '0;
                n_flags = '0;
                n_tags  = '0;
                n_done  = 1'b0;
                n_ptype = '0;
                n_pstag = 1'b0;
            end else if (r_pos != el2hp_pkg::POS_MAX) begin
                n_pos = r_pos + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_off   <= '0;
            r_shift <= '0;
            r_flags <= '0;
            r_tags  <= '0;
            r_done  <= 1'b0;
            r_ptype <= '0;
            r_pstag <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_off   <= n_off;
            r_shift <= n_shift;
            r_flags <= n_flags;
            r_tags  <= n_tags;
            r_done  <= n_done;
            r_ptype <= n_ptype;
            r_pstag <= n_pstag;
        end
    end

endmodule

@@ design/ethernet_l2_header_parser_unit.sv @@
// Top level of the Ethernet L2 header parser: configuration, byte parser, result register.
//
//   Channel | Direction | Content
//   s_*     | in        | one frame byte per transfer, tlast on the final byte
//   m_*     | out       | one verdict per frame
//   i_cfg_* | in        | register index and 16-bit value
//
// A verdict is presented in the cycle after the byte that settles it, from a
// single output register.
// A byte is taken while the output register is empty or being drained in the same cycle.
// Reset is synchronous and resets frame state, configuration and the output valid flag.
module ethernet_l2_header_parser_unit #(
    parameter int MAX_TAGS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [2:0] status, [18:3] frame_type, [24:19] header_len
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    el2hp_pkg::t_cfg    r_cfg;
    el2hp_pkg::t_result r_res;
    el2hp_pkg::t_result res;
    logic               r_m_valid;
    logic               accept;
    logic               emit;

    assign o_cfg_ready = 1'b1;
    assign s_tready    = !r_m_valid || m_tready;
    assign accept      = s_tvalid && s_tready;
    assign m_tvalid    = r_m_valid;
    assign m_tdata     = {7'd0, r_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.length_limit <= el2hp_pkg::RST_LENGTH_LIMIT;
            r_cfg.type_floor   <= el2hp_pkg::RST_TYPE_FLOOR;
            r_cfg.ctag_type    <= el2hp_pkg::RST_CTAG_TYPE;
            r_cfg.stag_type    <= el2hp_pkg::RST_STAG_TYPE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                el2hp_pkg::REG_LENGTH_LIMIT: r_cfg.length_limit <= i_cfg_data;
                el2hp_pkg::REG_TYPE_FLOOR:   r_cfg.type_floor   <= i_cfg_data;
                el2hp_pkg::REG_CTAG_TYPE:    r_cfg.ctag_type    <= i_cfg_data;
                el2hp_pkg::REG_STAG_TYPE:    r_cfg.stag_type    <= i_cfg_data;
                default:                     r_cfg              <= r_cfg;
            endcase
        end
    end

    el2hp_byte_parser #(
        .MAX_TAGS (MAX_TAGS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (accept),
        .i_byte   (s_tdata),
        .i_last   (s_tlast),
        .o_emit   (emit),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (accept && emit) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_res <= res;
        end
    end

endmodule

@@ design/el2hp_checker.sv @@
// Port-level checker of the Ethernet L2 header parser and its bind statement.
`include "assert_macros.svh"

module el2hp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_IMPLY(a_status_range, i_clk, i_rst_n, m_tvalid, m_tdata[2:0] <= el2hp_pkg::ST_TAGS)
    `ASSERT_IMPLY(a_no_len_on_reject, i_clk, i_rst_n, m_tvalid && (m_tdata[2:0] == el2hp_pkg::ST_BAD_TYPE || m_tdata[2:0] == el2hp_pkg::ST_LENGTH || m_tdata[2:0] == el2hp_pkg::ST_RUNT), m_tdata[24:19] == 6'd0)
    `ASSERT_IMPLY(a_runt_no_type, i_clk, i_rst_n, m_tvalid && m_tdata[2:0] == el2hp_pkg::ST_RUNT, m_tdata[18:3] == 16'd0)
    `ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !m_tvalid, s_tready)

endmodule

bind ethernet_l2_header_parser_unit el2hp_checker u_el2hp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/sv/tb_ethernet_l2_header_parser_unit.sv @@
// Testbench for the Ethernet L2 header parser: frame stimulus, verdict prediction and checking.
module tb_ethernet_l2_header_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import el2hp_pkg::*;

    localparam int TAG_LIMIT = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] TYPE_IPV6 = 16'h86DD;

    typedef enum int {
        ADDR_OK,
        ADDR_DST_ZERO,
        ADDR_DST_MCAST,
        ADDR_SRC_ZERO,
        ADDR_SRC_MCAST,
        ADDR_RANDOM
    } addr_kind_e;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
    logic        s_tlast = 1'b0;    // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [2:0] status, [18:3] frame_type, [24:19] header_len
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = REG_LENGTH_LIMIT;
    logic [15:0] i_cfg_data = 16'h0000;

    ethernet_l2_header_parser_unit #(
        .MAX_TAGS(TAG_LIMIT)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    t_cfg        cfg;
    logic [5:0]  pos;
    logic [5:0]  hdr_off;
    logic [15:0] shift;
    logic [3:0]  addr_flags;
    logic [2:0]  tag_cnt;
    logic        settled;
    logic [15:0] pend_type;
    logic        pend_stag;

    t_result     verdicts_due[$];
    logic [7:0]  frame_bytes[$];

    int mismatch_count = 0;
    int verdicts_checked = 0;
    int frames_sent = 0;
    int bytes_sent = 0;
    int config_writes = 0;
    int cycle_count = 0;
    int sink_hold = 0;
    bit quiet = 1'b0;

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void clear_frame();
        pos = 6'd0;
        hdr_off = 6'd0;
        shift = 16'h0000;
        addr_flags = 4'h0;
        tag_cnt = 3'd0;
        settled = 1'b0;
        pend_type = 16'h0000;
        pend_stag = 1'b0;
    endfunction

    function automatic bit post_verdict(logic [2:0] st, logic [15:0] ty, logic [5:0] len);
        t_result r;
        r.status = st;
        r.frame_type = ty;
        r.header_len = len;
        verdicts_due.push_back(r);
        settled = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit address_verdict(logic [15:0] ty);
        bit ok;
        ok = addr_flags[0] && !addr_flags[1] && addr_flags[2] && !addr_flags[3];
        return post_verdict(ok ? ST_ACCEPT : ST_NOT_UCAST, ty, hdr_off);
    endfunction

    function automatic bit walk_type(logic [15:0] ty);
        if (ty == cfg.ctag_type || ty == cfg.stag_type) begin
            if (tag_cnt >= TAG_LIMIT) begin
                return post_verdict(ST_TAGS, ty, hdr_off);
            end
            pend_type = ty;
            pend_stag = (ty != cfg.ctag_type);
            return 1'b0;
        end
        return address_verdict(ty);
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic last);
        logic [5:0] p;
        bit got;
        int side;
        int tag_end;
        p = pos;
        got = 1'b0;
        if (!settled) begin
            shift = {shift[7:0], b};
            if (p < POS_TYPE_HI) begin
                side = (p < POS_SRC_ADDR) ? 0 : 2;
                if (b != 8'h00) addr_flags[side] = 1'b1;
                if ((p == 6'd0 || p == POS_SRC_ADDR) && b[0]) addr_flags[side + 1] = 1'b1;
            end else if (p == POS_TYPE_LO) begin
                if (shift >= cfg.length_limit && shift <= cfg.type_floor) begin
                    got = post_verdict(ST_BAD_TYPE, shift, 6'd0);
                end else if (shift < cfg.length_limit) begin
                    got = post_verdict(ST_LENGTH, shift, 6'd0);
                end else begin
                    hdr_off = BASE_HDR_LEN;
                    got = walk_type(shift);
                end
            end else if (p > POS_TYPE_LO) begin
                tag_end = int'(hdr_off) + (pend_stag ? 7 : 3);
                if (int'(p) == tag_end) begin
                    hdr_off = hdr_off + (pend_stag ? 6'd8 : 6'd4);
                    tag_cnt++;
                    got = walk_type(shift);
                end
            end
            if (last && !got) begin
                if (p < POS_TYPE_LO) got = post_verdict(ST_RUNT, 16'h0000, 6'd0);
                else got = address_verdict(pend_type);
            end
        end
        if (last) clear_frame();
        else if (pos < POS_MAX) pos++;
    endfunction

    task automatic check_verdict(logic [31:0] word);
        t_result got;
        t_result want;
        got = word[24:0];
        if (verdicts_due.size() == 0) begin
            report_mismatch($sformatf("verdict %h arrived with none outstanding", word));
            return;
        end
        want = verdicts_due.pop_front();
        verdicts_checked++;
        if (word[31:25] != 7'd0)
            report_mismatch($sformatf("padding bits %h not zero", word[31:25]));
        if (got.status != want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.frame_type != want.frame_type)
            report_mismatch($sformatf("frame_type %h, expected %h",
                                      got.frame_type, want.frame_type));
        if (got.header_len != want.header_len)
            report_mismatch($sformatf("header_len %0d, expected %0d",
                                      got.header_len, want.header_len));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                check_verdict(m_tdata);
                sink_hold = quiet ? 0 : $urandom_range(0, 3);
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
        frame_bytes.delete();
        frames_sent++;
    endtask

    // Stops the source and waits until every outstanding verdict has been taken.
    task automatic pause_source();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_config(t_cfg next);
        logic [1:0] idx;
        logic [15:0] value;
        pause_source();
        for (int r = 0; r < 4; r++) begin
            idx = 2'(r);
            case (idx)
                REG_LENGTH_LIMIT: value = next.length_limit;
                REG_TYPE_FLOOR:   value = next.type_floor;
                REG_CTAG_TYPE:    value = next.ctag_type;
                default:          value = next.stag_type;
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= value;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (idx)
                REG_LENGTH_LIMIT: cfg.length_limit = value;
                REG_TYPE_FLOOR:   cfg.type_floor = value;
                REG_CTAG_TYPE:    cfg.ctag_type = value;
                default:          cfg.stag_type = value;
            endcase
            config_writes++;
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_cfg default_cfg();
        t_cfg c;
        c.length_limit = RST_LENGTH_LIMIT;
        c.type_floor = RST_TYPE_FLOOR;
        c.ctag_type = RST_CTAG_TYPE;
        c.stag_type = RST_STAG_TYPE;
        return c;
    endfunction

    function automatic void add_word(logic [15:0] v);
        frame_bytes.push_back(v[15:8]);
        frame_bytes.push_back(v[7:0]);
    endfunction

    function automatic void add_fill(int n);
        for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom));
    endfunction

    function automatic void add_addrs(addr_kind_e kind);
        bit zero;
        bit mcast;
        bit any_nz;
        logic [7:0] b;
        for (int side = 0; side < 2; side++) begin
            zero = (kind == ADDR_DST_ZERO && side == 0) || (kind == ADDR_SRC_ZERO && side == 1);
            mcast = (kind == ADDR_DST_MCAST && side == 0) || (kind == ADDR_SRC_MCAST && side == 1);
            any_nz = 1'b0;
            for (int i = 0; i < 6; i++) begin
                b = 8'($urandom);
                if (kind == ADDR_RANDOM && $urandom_range(0, 1) == 0) b = 8'h00;
                if (zero) b = 8'h00;
                if (kind != ADDR_RANDOM && !zero) begin
                    if (i == 0) b[0] = mcast;
                    if (i == 5 && !any_nz && b == 8'h00) b = 8'h02;
                end
                if (b != 8'h00) any_nz = 1'b1;
                frame_bytes.push_back(b);
            end
        end
    endfunction

    function automatic logic [15:0] pick_type();
        int unsigned ll;
        int unsigned tf;
        ll = cfg.length_limit;
        tf = cfg.type_floor;
        case ($urandom_range(0, 11))
            0: return 16'($urandom);
            1: return (ll > 0) ? 16'($urandom_range(ll - 1, 0)) : 16'($urandom);
            2: return (ll <= tf) ? 16'($urandom_range(tf, ll)) : 16'($urandom);
            3: return cfg.length_limit - 16'd1;
            4: return cfg.type_floor + 16'd1;
            5: return ($urandom_range(0, 1) == 1) ? cfg.length_limit : cfg.type_floor;
            6: return TYPE_IPV6;
            default: return (tf < 65535) ? 16'($urandom_range(65535, tf + 1)) : 16'($urandom);
        endcase
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.length_limit = 16'($urandom);
        c.type_floor = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : c.length_limit + 16'($urandom_range(0, 200));
        c.ctag_type = ($urandom_range(0, 1) == 1) ? RST_CTAG_TYPE : 16'($urandom);
        c.stag_type = ($urandom_range(0, 1) == 1) ? RST_STAG_TYPE : 16'($urandom);
        return c;
    endfunction

    task automatic send_random_frame();
        addr_kind_e kind;
        int ntags;
        int cut;
        bit stag;
        if ($urandom_range(0, 99) < 8) begin
            add_fill($urandom_range(1, 40));
        end else begin
            kind = ($urandom_range(0, 99) < 75) ? ADDR_OK : addr_kind_e'($urandom_range(1, 5));
            add_addrs(kind);
            ntags = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, TAG_LIMIT + 1);
            for (int k = 0; k < ntags; k++) begin
                stag = $urandom_range(0, 1);
                add_word(stag ? cfg.stag_type : cfg.ctag_type);
                add_fill(stag ? 6 : 2);
            end
            add_word(pick_type());
            add_fill($urandom_range(0, 10));
            if ($urandom_range(0, 4) == 0) begin
                cut = $urandom_range(1, frame_bytes.size());
                while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            end
        end
        send_frame();
    endtask

    task automatic test_type_ranges();
        logic [15:0] types[7];
        types = '{TYPE_IPV4, RST_LENGTH_LIMIT, RST_TYPE_FLOOR, RST_LENGTH_LIMIT - 16'd1,
                  16'h0000, RST_TYPE_FLOOR + 16'd1, 16'hFFFF};
        foreach (types[i]) begin
            add_addrs(ADDR_OK);
            add_word(types[i]);
            add_fill(2);
            send_frame();
        end
    endtask

    task automatic test_address_checks();
        for (int k = ADDR_DST_ZERO; k <= ADDR_SRC_MCAST; k++) begin
            add_addrs(addr_kind_e'(k));
            add_word(TYPE_IPV4);
            send_frame();
        end
        add_addrs(ADDR_DST_MCAST);
        add_word(16'h0040);
        send_frame();
    endtask

    task automatic test_runt_frames();
        add_fill(1);
        send_frame();
        add_addrs(ADDR_OK);
        send_frame();
        add_addrs(ADDR_OK);
        frame_bytes.push_back(8'h08);
        send_frame();
        add_addrs(ADDR_OK);
        add_word(RST_CTAG_TYPE);
        send_frame();
    endtask

    task automatic test_vlan_walk();
        add_addrs(ADDR_OK);
        add_word(RST_CTAG_TYPE);
        add_fill(2);
        add_word(TYPE_IPV4);
        send_frame();
        add_addrs(ADDR_OK);
        add_word(RST_STAG_TYPE);
        add_fill(6);
        add_word(TYPE_IPV6);
        add_fill(3);
        send_frame();
        for (int n = TAG_LIMIT; n <= TAG_LIMIT + 1; n++) begin
            add_addrs((n > TAG_LIMIT) ? ADDR_SRC_MCAST : ADDR_OK);
            for (int k = 0; k < n; k++) begin
                add_word((k == 1) ? RST_STAG_TYPE : RST_CTAG_TYPE);
                add_fill((k == 1) ? 6 : 2);
            end
            add_word(TYPE_IPV4);
            send_frame();
        end
        add_addrs(ADDR_OK);
        add_word(RST_STAG_TYPE);
        add_fill(3);
        send_frame();
        add_addrs(ADDR_OK);
        add_word(RST_CTAG_TYPE);
        add_fill(2);
        add_word(RST_CTAG_TYPE);
        add_fill(1);
        send_frame();
        add_addrs(ADDR_OK);
        add_word(TYPE_IPV4);
        add_fill(70);
        send_frame();
    endtask

    task automatic test_config_corners();
        t_cfg c;
        c = '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF};
        apply_config(c);
        for (int i = 0; i < 3; i++) begin
            add_addrs(ADDR_OK);
            add_word((i == 2) ? 16'hFFFF : 16'(i));
            add_fill(6);
            add_word(16'h0001);
            send_frame();
        end
        c = '{16'hFFFF, 16'hFFFF, 16'h9100, 16'h9100};
        apply_config(c);
        add_addrs(ADDR_OK);
        add_word(16'hFFFF);
        send_frame();
        add_addrs(ADDR_OK);
        add_word(16'hFFFE);
        send_frame();
        c = '{RST_LENGTH_LIMIT, RST_TYPE_FLOOR, 16'h9100, 16'h9100};
        apply_config(c);
        add_addrs(ADDR_OK);
        add_word(16'h9100);
        add_fill(2);
        add_word(TYPE_IPV4);
        add_fill(6);
        send_frame();
    endtask

    task automatic test_random_traffic(t_cfg c, int budget);
        int start;
        apply_config(c);
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            send_random_frame();
            if ($urandom_range(0, 9) == 0) pause_source();
        end
    endtask

    task automatic test_steady_stream(int budget);
        quiet = 1'b1;
        test_random_traffic(default_cfg(), budget);
        pause_source();
        quiet = 1'b0;
    endtask

    initial begin
        cfg = default_cfg();
        clear_frame();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_type_ranges();
        test_address_checks();
        test_runt_frames();
        test_vlan_walk();
        test_config_corners();

        test_random_traffic(default_cfg(), 350);
        test_random_traffic(random_cfg(), 200);
        test_random_traffic('{16'h0000, 16'h0000, RST_CTAG_TYPE, RST_STAG_TYPE}, 180);
        test_random_traffic('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000}, 150);
        test_random_traffic('{16'h0700, 16'h0600, RST_STAG_TYPE, RST_STAG_TYPE}, 180);
        test_random_traffic(random_cfg(), 150);
        test_steady_stream(180);

        pause_source();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d frames (%0d bytes) over %0d register writes, %0d verdicts checked.",
                 frames_sent, bytes_sent, config_writes, verdicts_checked);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches found", mismatch_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
